### rtl/core/ukf_pkg.sv
// Shared types, status codes and the response builder for the unique-key queue.
package ukf_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int KEY_W           = 32;
  localparam int DATA_W          = 32;
  localparam int CNT_W           = 5;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t                   opcode;
    logic signed [KEY_W-1:0]   entry_key;
    logic signed [DATA_W-1:0]  entry_data;
  } req_t;

  typedef struct packed {
    status_t                   status;
    logic signed [KEY_W-1:0]   out_key;
    logic signed [DATA_W-1:0]  out_data;
    logic [CNT_W-1:0]          entry_count;
    logic                      is_empty;
  } rsp_t;

  function automatic rsp_t make_rsp(input status_t                  st,
                                    input logic signed [KEY_W-1:0]  k,
                                    input logic signed [DATA_W-1:0] d,
                                    input logic [CNT_W-1:0]         cnt,
                                    input logic                     empty);
    rsp_t r;
    r.status      = st;
    r.out_key     = k;
    r.out_data    = d;
    r.entry_count = cnt;
    r.is_empty    = empty;
    return r;
  endfunction

endpackage

### rtl/core/ukf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ukf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/unique_key_fifo.sv
// Top level of the first-in first-out queue that rejects duplicate keys.
//
// Usage: drive req and raise start while busy is low; the request is taken
// at that clock edge. req.opcode selects enqueue of (entry_key, entry_data)
// or dequeue of the oldest entry. Exactly one response follows per request:
// done is high for one cycle with rsp holding status, the dequeued entry
// (zero unless a dequeue succeeded), the entry count and an empty flag.
// The receiver cannot stall; rsp is valid only while done is high.
// Sequence (start edge to done): dequeue of an empty queue and enqueue
// into an empty queue are answered straight from idle, a dequeue passes
// through the head-read state, and an enqueue against held entries first
// walks them on the key memory's single read port: the duplicate check walks
// the held keys one slot per cycle through one shared comparator, and stops
// at the first match. busy is low again in the cycle done is high, so a new
// request may start there. Reset clears head, tail and count; memory
// contents are not cleared and are never read before being written.
module unique_key_fifo
  import ukf_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic done,
  output rsp_t rsp
);

  localparam int              AW         = $clog2(QUEUE_DEPTH);
  localparam int              CW         = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0]   LAST_SLOT  = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0]   FULL_COUNT = CW'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DEQ  = 3'b100
  } state_t;

  state_t                  state, state_next;
  logic [AW-1:0]           head, head_next;
  logic [AW-1:0]           tail, tail_next;
  logic [CW-1:0]           fill, fill_next;
  logic [AW-1:0]           slot, slot_next;
  logic [CW-1:0]           issued, issued_next;
  logic                    pend, pend_next;
  req_t                    cmd, cmd_next;
  logic                    done_next;
  rsp_t                    rsp_next;

  logic                    wr_en;
  req_t                    wr_req;
  logic [AW-1:0]           raddr;
  logic [KEY_W-1:0]        key_rd;
  logic [DATA_W-1:0]       data_rd;
  logic                    hit;

  function automatic logic [AW-1:0] step_slot(input logic [AW-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + AW'(1);
  endfunction

  // read the head slot when a request arrives, else the walk slot
  assign raddr = (state == S_IDLE) ? head : slot;
  assign busy  = (state != S_IDLE);

  // shared key comparator over the walked slot
  assign hit = pend && (key_rd == cmd.entry_key);

  ukf_ram #(.WIDTH(KEY_W), .DEPTH(QUEUE_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (tail),
    .wdata (wr_req.entry_key),
    .raddr (raddr),
    .rdata (key_rd)
  );

  ukf_ram #(.WIDTH(DATA_W), .DEPTH(QUEUE_DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (tail),
    .wdata (wr_req.entry_data),
    .raddr (raddr),
    .rdata (data_rd)
  );

  // sequencer: take request, walk keys or read head, then respond
  always_comb begin
    state_next  = state;
    head_next   = head;
    tail_next   = tail;
    fill_next   = fill;
    slot_next   = slot;
    issued_next = issued;
    pend_next   = 1'b0;
    cmd_next    = cmd;
    done_next   = 1'b0;
    rsp_next    = rsp;
    wr_en       = 1'b0;
    wr_req      = req;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd_next = req;
          if (req.opcode == OP_DEQ) begin
            if (fill == '0) begin
              done_next = 1'b1;
              rsp_next  = make_rsp(ST_EMPTY, '0, '0, CNT_W'(fill), 1'b1);
            end else begin
              state_next = S_DEQ;
            end
          end else if (fill == '0) begin
            // empty queue: no key to compare against, accept at once
            wr_en     = 1'b1;
            tail_next = step_slot(tail);
            fill_next = fill + CW'(1);
            done_next = 1'b1;
            rsp_next  = make_rsp(ST_OK, '0, '0, CNT_W'(fill + CW'(1)), 1'b0);
          end else begin
            state_next  = S_WALK;
            slot_next   = head;
            issued_next = '0;
          end
        end
      end

      S_WALK: begin
        wr_req = cmd;
        // issue the next key read while slots remain
        if (issued != fill) begin
          slot_next   = step_slot(slot);
          issued_next = issued + CW'(1);
          pend_next   = 1'b1;
        end
        if (hit) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
          rsp_next   = make_rsp(ST_DUP, '0, '0, CNT_W'(fill), 1'b0);
        end else if (issued == fill) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
          if (fill == FULL_COUNT) begin
            rsp_next = make_rsp(ST_FULL, '0, '0, CNT_W'(fill), 1'b0);
          end else begin
            wr_en     = 1'b1;
            tail_next = step_slot(tail);
            fill_next = fill + CW'(1);
            rsp_next  = make_rsp(ST_OK, '0, '0, CNT_W'(fill + CW'(1)), 1'b0);
          end
        end
      end

      S_DEQ: begin
        // head entry is on the read ports now
        state_next = S_IDLE;
        head_next  = step_slot(head);
        fill_next  = fill - CW'(1);
        done_next  = 1'b1;
        rsp_next   = make_rsp(ST_OK, key_rd, data_rd, CNT_W'(fill - CW'(1)),
                              (fill == CW'(1)));
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      fill  <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      fill  <= fill_next;
      pend  <= pend_next;
      done  <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    slot   <= slot_next;
    issued <= issued_next;
    cmd    <= cmd_next;
    rsp    <= rsp_next;
  end

  // a response is only shown once the sequencer is back at rest
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("response strobe while sequencer busy");

  // the count never passes the queue depth
  assert property (@(posedge clk) disable iff (rst) fill <= FULL_COUNT)
    else $error("entry count exceeds queue depth");

  // a dequeue of an empty queue answers in the next cycle with empty status
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.opcode == OP_DEQ && fill == '0)
      |=> (done && rsp.status == ST_EMPTY))
    else $error("empty dequeue not answered at once");

  // a walk ends with the key read pointer having covered at most the count
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (issued <= fill))
    else $error("key walk ran past held entries");

endmodule
